// File: rtl/rrut_pkg.sv
`timescale 1ns / 1ps

package rrut_pkg;

	// Event codes carried in the action field of an input beat.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_UNIT  = 2'd1,
		ACT_INDEX = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RING_BASE  = 3'd0,
		CFG_RING_END   = 3'd1,
		CFG_RING_BYTES = 3'd2,
		CFG_UNIT_BYTES = 3'd3,
		CFG_UNIT_COUNT = 3'd4,
		CFG_WARN_LEVEL = 3'd5,
		CFG_WARN_GAP   = 3'd6
	} cfg_reg_t;

	// Width of the unit number as it is reported and stored in the index table.
	localparam int UNIT_W = 6;

	typedef struct packed {
		logic [31:0]       free_bytes;
		logic              overflow;
		logic              almost_full_warn;
		logic              counter_mismatch;
		logic              addr_resynced;
		logic              unit_resynced;
		logic [31:0]       write_addr;
		logic [UNIT_W-1:0] current_unit;
		logic [7:0]        index_slot;
		logic [15:0]       overflow_total;
	} res_t;

endpackage

// File: rtl/rrut_ram.sv
`timescale 1ns / 1ps

// Single-port synchronous RAM with a registered read.
module rrut_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rrut_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A zero divisor gives a
// quotient of all ones and the dividend as remainder.
module rrut_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	assign fits  = ~trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: rtl/record_ring_unit_tracker.sv
`timescale 1ns / 1ps

// Write-side tracker for a recording ring buffer divided into unit buffers.
// Input beats carry one event: a millisecond tick, a unit-done event with the
// hardware write pointer, hardware buffer counter and reader pointer, or a
// start-code index word. Every accepted beat yields exactly one result beat.
// Both streams use valid and stall; a beat moves when valid is high and
// stall is low. Configuration registers are written on their own valid and
// ready channel, which is always ready, and must only be written while idle.
// Three iterative dividers (32 steps for free space and aligned unit, 9 steps
// for unit wrap) run side by side on a unit-done event; once all of them
// finish, the multiply state, the update state, the state that moves the
// result into the output register and the idle state in which the next beat
// is taken follow in order. The counter wrap comes from a constant table.
// Tick, index and no-op events skip the dividers and the multiply state and
// go from the idle state straight to the update state. The block holds
// one event at a time. A finished result waits in the output register while
// the next event is already accepted; if the receiver still stalls when that
// next result is ready, the block holds it and does not accept further beats.
// Reset clears the pointers, counters and tallies, enables warnings and loads
// the register defaults; the index table is not cleared and needs no sweep.
module record_ring_unit_tracker #(
	parameter int INDEX_DEPTH  = 256,
	parameter int COUNTER_WRAP = 256,
	parameter int MAX_UNITS    = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [31:0]                    hw_write_addr,
	input  logic [7:0]                     hw_unit_counter,
	input  logic [31:0]                    reader_addr,
	input  logic [31:0]                    index_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    free_bytes,
	output logic                           overflow,
	output logic                           almost_full_warn,
	output logic                           counter_mismatch,
	output logic                           addr_resynced,
	output logic                           unit_resynced,
	output logic [31:0]                    write_addr,
	output logic [rrut_pkg::UNIT_W-1:0]    current_unit,
	output logic [7:0]                     index_slot,
	output logic [15:0]                    overflow_total,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rrut_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	import rrut_pkg::*;

	localparam int IW = $clog2(INDEX_DEPTH);
	localparam int SW = 9;
	localparam logic [8:0]    MAXU_C   = 9'(MAX_UNITS);
	localparam logic [IW-1:0] POS_LAST = IW'(INDEX_DEPTH - 1);

	// Next expected hardware counter for every counter value, that is the
	// value plus one modulo COUNTER_WRAP, built as a constant table.
	typedef logic [255:0][7:0] cnt_tab_t;

	function automatic cnt_tab_t build_cnt_tab();
		cnt_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = 8'((i + 1) % COUNTER_WRAP);
		end
		return tab;
	endfunction

	localparam cnt_tab_t CNT_NEXT = build_cnt_tab();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_FIN,
		ST_SEND
	} state_t;

	// Configuration registers.
	logic [31:0] ring_base_q;
	logic [31:0] ring_end_q;
	logic [31:0] ring_bytes_q;
	logic [23:0] unit_bytes_q;
	logic [6:0]  unit_count_q;
	logic [31:0] warn_level_q;
	logic [15:0] warn_gap_q;

	// Tracker state.
	state_t      state_q;
	logic [31:0] wp_q;
	logic [6:0]  unit_q;
	logic [7:0]  exp_q;
	logic        warn_en_q;
	logic [31:0] last_warn_q;
	logic [31:0] now_q;
	logic [15:0] tally_q;
	logic [IW-1:0] pos_q;
	logic        out_valid_q;

	// Per-event working registers.
	action_t     act_q;
	logic [31:0] word_q;
	logic        mism_q;
	logic [7:0]  cnt_nxt_q;
	logic [31:0] prod_q;
	logic [31:0] adv_q;
	logic        ovf_q;
	logic        warn_q;
	res_t        res_q;
	res_t        out_q;

	logic in_acc;
	logic div_start;
	logic out_load;
	logic busy_any;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign div_start = in_acc && (action_t'(action) == ACT_UNIT);
	assign out_load  = (state_q == ST_SEND) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// Configuration writes. Indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_base_q  <= '0;
			ring_end_q   <= '0;
			ring_bytes_q <= 32'd1;
			unit_bytes_q <= 24'd1;
			unit_count_q <= 7'd1;
			warn_level_q <= '0;
			warn_gap_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RING_BASE:  ring_base_q  <= cfg_data;
				CFG_RING_END:   ring_end_q   <= cfg_data;
				CFG_RING_BYTES: ring_bytes_q <= cfg_data;
				CFG_UNIT_BYTES: unit_bytes_q <= cfg_data[23:0];
				CFG_UNIT_COUNT: unit_count_q <= cfg_data[6:0];
				CFG_WARN_LEVEL: warn_level_q <= cfg_data;
				CFG_WARN_GAP:   warn_gap_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The unit count is clamped to the range one to MAX_UNITS.
	logic [6:0] eff_units;

	always_comb begin
		if (unit_count_q == 7'd0) begin
			eff_units = 7'd1;
		end else if ({2'b00, unit_count_q} > MAXU_C) begin
			eff_units = MAXU_C[6:0];
		end else begin
			eff_units = unit_count_q;
		end
	end

	// Dividers. All three are loaded at the edge that accepts a unit-done beat,
	// so they see the state as it was before the event.
	logic [31:0]   free_dvd;
	logic [31:0]   algn_dvd;
	logic [7:0]    unit_inc;
	logic [SW-1:0] unit_dvd;
	logic [31:0]   free_rem;
	logic [31:0]   algn_quo;
	logic [SW-1:0] unit_rem;
	logic          busy_free;
	logic          busy_algn;
	logic          busy_unit;

	assign free_dvd = reader_addr + ring_bytes_q - (wp_q + 32'd1);
	assign algn_dvd = hw_write_addr - ring_base_q;
	assign unit_inc = {1'b0, unit_q} + 8'd1;
	assign unit_dvd = {1'b0, unit_inc};
	assign busy_any = busy_free || busy_algn || busy_unit;

	rrut_div #(.W(32)) u_div_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (free_dvd),
		.divisor   (ring_bytes_q),
		.busy      (busy_free),
		.quotient  (),
		.remainder (free_rem)
	);

	rrut_div #(.W(32)) u_div_algn (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (algn_dvd),
		.divisor   ({8'd0, unit_bytes_q}),
		.busy      (busy_algn),
		.quotient  (algn_quo),
		.remainder ()
	);

	rrut_div #(.W(SW)) u_div_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (unit_dvd),
		.divisor   ({2'b00, eff_units}),
		.busy      (busy_unit),
		.quotient  (),
		.remainder (unit_rem)
	);

	// Multiply stage: aligned offset, pointer advance and the warning checks.
	logic [55:0] prod_full;
	logic [31:0] adv_sum;
	logic [31:0] adv_c;
	logic [31:0] elapsed;
	logic        ovf_c;
	logic        warn_c;

	always_comb begin
		prod_full = algn_quo * unit_bytes_q;
		adv_sum   = wp_q + {8'd0, unit_bytes_q};
		adv_c     = (adv_sum >= ring_end_q) ? ring_base_q : adv_sum;
		elapsed   = now_q - last_warn_q;
		ovf_c     = (free_rem <= {8'd0, unit_bytes_q});
		warn_c    = !ovf_c && (free_rem < warn_level_q) && warn_en_q
			&& (elapsed >= {16'd0, warn_gap_q});
	end

	// Update stage: resync decisions and the result beat.
	logic [31:0]   aligned;
	logic [6:0]    unit_adv;
	logic          unit_rs;
	logic [6:0]    unit_new;
	logic [15:0]   tally_nxt;
	logic [IW+7:0] pos_ext;
	logic [IW-1:0] pos_nxt;
	res_t          fin_res;

	always_comb begin
		aligned   = ring_base_q + prod_q;
		unit_adv  = unit_rem[6:0];
		unit_rs   = (algn_quo != {25'd0, unit_adv});
		unit_new  = unit_rs ? {1'b0, algn_quo[UNIT_W-1:0]} : unit_adv;
		tally_nxt = (ovf_q && (tally_q != 16'hFFFF)) ? tally_q + 16'd1 : tally_q;
		pos_ext   = {8'd0, pos_q};
		pos_nxt   = (pos_q == POS_LAST) ? '0 : pos_q + IW'(1);

		fin_res                = '0;
		fin_res.write_addr     = wp_q;
		fin_res.current_unit   = unit_q[UNIT_W-1:0];
		fin_res.overflow_total = tally_q;
		case (act_q)
			ACT_UNIT: begin
				fin_res.free_bytes       = free_rem;
				fin_res.overflow         = ovf_q;
				fin_res.almost_full_warn = warn_q;
				fin_res.counter_mismatch = mism_q;
				fin_res.addr_resynced    = (aligned != adv_q);
				fin_res.unit_resynced    = unit_rs;
				fin_res.write_addr       = aligned;
				fin_res.current_unit     = unit_new[UNIT_W-1:0];
				fin_res.overflow_total   = tally_nxt;
			end
			ACT_INDEX: begin
				fin_res.index_slot = pos_ext[7:0];
			end
			default: begin
			end
		endcase
	end

	// Index table: picture index word and the unit it arrived in.
	logic ram_we;

	assign ram_we = (state_q == ST_FIN) && (act_q == ACT_INDEX);

	rrut_ram #(
		.WIDTH (32 + UNIT_W),
		.DEPTH (INDEX_DEPTH)
	) u_index_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (pos_q),
		.wdata ({word_q, unit_q[UNIT_W-1:0]}),
		.rdata ()
	);

	// Sequencer with the tracker state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			unit_q      <= '0;
			exp_q       <= '0;
			warn_en_q   <= 1'b1;
			last_warn_q <= '0;
			now_q       <= '0;
			tally_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= div_start ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (!busy_any) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_SEND;
					case (act_q)
						ACT_TICK: begin
							now_q <= now_q + 32'd1;
						end
						ACT_UNIT: begin
							wp_q    <= aligned;
							unit_q  <= unit_new;
							exp_q   <= cnt_nxt_q;
							tally_q <= tally_nxt;
							if (ovf_q) begin
								warn_en_q <= 1'b0;
							end
							if (warn_q) begin
								last_warn_q <= now_q;
							end
						end
						ACT_INDEX: begin
							pos_q <= pos_nxt;
						end
						default: begin
						end
					endcase
				end
				ST_SEND: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q     <= action_t'(action);
			word_q    <= index_word;
			mism_q    <= (hw_unit_counter != exp_q);
			cnt_nxt_q <= CNT_NEXT[hw_unit_counter];
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[31:0];
			adv_q  <= adv_c;
			ovf_q  <= ovf_c;
			warn_q <= warn_c;
		end
		if (state_q == ST_FIN) begin
			res_q <= fin_res;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign free_bytes       = out_q.free_bytes;
	assign overflow         = out_q.overflow;
	assign almost_full_warn = out_q.almost_full_warn;
	assign counter_mismatch = out_q.counter_mismatch;
	assign addr_resynced    = out_q.addr_resynced;
	assign unit_resynced    = out_q.unit_resynced;
	assign write_addr       = out_q.write_addr;
	assign current_unit     = out_q.current_unit;
	assign index_slot       = out_q.index_slot;
	assign overflow_total   = out_q.overflow_total;

endmodule
